// ===== sv/ils_pkg.sv =====
`default_nettype none
package ils_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = AW + 1;

  localparam logic [2:0] ACT_APPEND     = 3'd0;
  localparam logic [2:0] ACT_DROP_FIRST = 3'd1;
  localparam logic [2:0] ACT_DROP_LAST  = 3'd2;
  localparam logic [2:0] ACT_INSERT     = 3'd3;
  localparam logic [2:0] ACT_REMOVE_AT  = 3'd4;

  typedef logic [CW-1:0] count_t;
  typedef logic [AW-1:0] addr_t;

endpackage
`default_nettype wire

// ===== sv/indexed_list_store_unit.sv =====
// Ordered list of up to CAPACITY signed 32-bit words with indexed insert/remove.
// Input channel (in_valid/in_stall): action, position, item_value. One word in
// gives exactly one result word on the output channel (out_valid/out_stall):
// out_ok is 1 when the list changed, out_length is the count afterwards.
// in_stall is high from the accept until the result has been loaded into the
// output register, so one request is worked on at a time.
// Drop last, a remove of the last entry and any rejected request go from the
// accept straight to the final step; append and insert at the end pass through
// the put step first. An insert that moves k entries does k read/write pairs
// and then the put step; a remove that moves k entries does k read/write pairs
// only: every move is a read of the entry store followed by a write, through
// its single read and write port, with one shared index adder stepping the
// address. The next word can be accepted in the same cycle that out_valid rises.
// The result sits in an output register; while out_stall is high, a pending
// result holds, the sequencer waits in its final step, the input stays stalled.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; the entry store itself is not cleared, stale entries are never read.
`default_nettype none
module indexed_list_store_unit
  import ils_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [2:0]         in_action,
  input  wire logic [8:0]         in_position,
  input  wire logic signed [31:0] in_item_value,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic               out_ok,
  output      logic [8:0]         out_length
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_WR   = 3'd2;
  localparam logic [2:0] ST_PUT  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam count_t CAP_C = count_t'(CAPACITY);

  logic [2:0]   state_r, state_nxt;
  count_t       count_r, count_nxt;
  count_t       idx_r, idx_nxt;
  count_t       end_r, end_nxt;
  count_t       pos_r, pos_nxt;
  logic         down_r, down_nxt;
  logic         ok_r, ok_nxt;
  logic [31:0]  value_r, value_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_ok_r, out_ok_nxt;
  count_t       out_length_r, out_length_nxt;

  logic [31:0]  mem [CAPACITY];
  logic [31:0]  rdata_r;
  logic         we;
  addr_t        waddr;
  logic [31:0]  wdata;

  count_t       nb;
  count_t       pos_in;
  logic         in_acc;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign pos_in = count_t'(in_position);

  // shared index unit: neighbor entry of the current one
  assign nb = down_r ? (idx_r - 1'b1) : (idx_r + 1'b1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    end_nxt        = end_r;
    pos_nxt        = pos_r;
    down_nxt       = down_r;
    ok_nxt         = ok_r;
    value_nxt      = value_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_ok_nxt     = out_ok_r;
    out_length_nxt = out_length_r;
    we             = 1'b0;
    waddr          = idx_r[AW-1:0];
    wdata          = rdata_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          value_nxt = in_item_value;
          ok_nxt    = 1'b0;
          state_nxt = ST_FIN;
          case (in_action)
            ACT_APPEND: begin
              if (count_r < CAP_C) begin
                pos_nxt   = count_r;
                state_nxt = ST_PUT;
              end
            end
            ACT_INSERT: begin
              if (pos_in <= count_r && count_r < CAP_C) begin
                pos_nxt = pos_in;
                if (pos_in == count_r) begin
                  state_nxt = ST_PUT;
                end else begin
                  idx_nxt   = count_r;
                  end_nxt   = pos_in;
                  down_nxt  = 1'b1;
                  state_nxt = ST_RD;
                end
              end
            end
            ACT_DROP_LAST: begin
              if (count_r != '0) begin
                ok_nxt    = 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            ACT_DROP_FIRST, ACT_REMOVE_AT: begin
              if (in_action == ACT_DROP_FIRST) begin
                pos_nxt = '0;
              end else begin
                pos_nxt = pos_in;
              end
              if (pos_nxt < count_r) begin
                ok_nxt    = 1'b1;
                count_nxt = count_r - 1'b1;
                if (pos_nxt != count_r - 1'b1) begin
                  idx_nxt   = pos_nxt;
                  end_nxt   = count_r - 1'b1;
                  down_nxt  = 1'b0;
                  state_nxt = ST_RD;
                end
              end
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        we      = 1'b1;
        waddr   = idx_r[AW-1:0];
        wdata   = rdata_r;
        idx_nxt = nb;
        if (nb == end_r) begin
          state_nxt = down_r ? ST_PUT : ST_FIN;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_PUT: begin
        we        = 1'b1;
        waddr     = pos_r[AW-1:0];
        wdata     = value_r;
        ok_nxt    = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = ok_r;
          out_length_nxt = count_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    end_r        <= end_nxt;
    pos_r        <= pos_nxt;
    down_r       <= down_nxt;
    ok_r         <= ok_nxt;
    value_r      <= value_nxt;
    out_ok_r     <= out_ok_nxt;
    out_length_r <= out_length_nxt;
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[nb[AW-1:0]];
  end

  assign out_valid  = out_valid_r;
  assign out_ok     = out_ok_r;
  assign out_length = out_length_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("list count above capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("accepted word did not start the sequencer");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR |-> idx_r < CAP_C && nb < CAP_C)
    else $error("shift index outside the entry store");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && !out_stall |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not loaded when output was free");

endmodule
`default_nettype wire
